>>> rtl/sit_pkg.sv
`timescale 1ns / 1ps

package sit_pkg;

    // Width of a sort key: 10*d0 + d1 with d0, d1 in -48..207 fits in 13 signed bits.
    localparam int KEY_W = 13;

    localparam logic [7:0] DIGIT_ZERO = 8'd48;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  index;
        logic [15:0] text_head;
        logic [63:0] text_tail;
    } sit_in_t;

    typedef struct packed {
        logic [15:0] entry_head;
        logic [63:0] entry_tail;
        logic [6:0]  fill_count;
        logic        error;
    } sit_out_t;

    typedef struct packed {
        logic [15:0] head;
        logic [63:0] tail;
    } sit_rec_t;

    // Control that the sequencer broadcasts to every cell of the row.
    typedef struct packed {
        logic                    cmp_en;
        logic                    load_en;
        logic                    ins;
        logic signed [KEY_W-1:0] key;
    } sit_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } sit_state_t;

    // Sort key from the two head characters, each taken as a raw byte minus '0'.
    function automatic logic signed [KEY_W-1:0] key_of(input logic [15:0] head);
        logic signed [KEY_W-1:0] d0;
        logic signed [KEY_W-1:0] d1;
        d0 = $signed({5'b0, head[15:8]}) - $signed({5'b0, DIGIT_ZERO});
        d1 = $signed({5'b0, head[7:0]}) - $signed({5'b0, DIGIT_ZERO});
        return (d0 <<< 3) + (d0 <<< 1) + d1;
    endfunction

endpackage

>>> rtl/sit_cell.sv
`timescale 1ns / 1ps

module sit_cell
    import sit_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  sit_ctl_t ctl_i,
    input  sit_rec_t new_rec_i,
    input  sit_rec_t left_rec_i,
    input  logic     left_valid_i,
    input  logic     left_found_i,
    output sit_rec_t rec_o,
    output logic     valid_o,
    output logic     found_o
);

    sit_rec_t rec_reg;
    logic     valid_reg;
    logic     match_reg;

    // A cell matches if it holds a record not smaller than the new key, or if it is
    // the first empty slot. Appends only ever match the first empty slot.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            if (ctl_i.cmp_en) begin
                if (valid_reg) begin
                    match_reg <= ctl_i.ins && (ctl_i.key <= key_of(rec_reg.head));
                end else begin
                    match_reg <= left_valid_i;
                end
            end
            if (ctl_i.load_en) begin
                if (left_found_i) begin
                    valid_reg <= left_valid_i;
                end else if (match_reg) begin
                    valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_i.load_en) begin
            if (left_found_i) begin
                rec_reg <= left_rec_i;
            end else if (match_reg) begin
                rec_reg <= new_rec_i;
            end
        end
    end

    assign rec_o   = rec_reg;
    assign valid_o = valid_reg;
    assign found_o = left_found_i | match_reg;

endmodule

>>> rtl/sorted_insert_table.sv
`timescale 1ns / 1ps

// Channel   Direction   Type       Handshake
// s_        in          sit_in_t   s_valid / s_ready
// m_        out         sit_out_t  m_valid / m_ready
//
// Each word goes through these steps in order: it is accepted, then every cell
// compares its record with the new key, then the row shifts and the result is
// loaded into the output register. The last step waits while the output register
// still holds a result that has not been taken. Reset clears the count and all
// cell valid bits, so the table starts empty; record payloads are not cleared.
// A new word is accepted while a finished result waits on the m_ side.

module sorted_insert_table
    import sit_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sit_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output sit_out_t m_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    sit_state_t              state_reg;
    sit_state_t              state_next;
    logic [1:0]              cmd_reg;
    logic [5:0]              index_reg;
    sit_rec_t                rec_in_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    sit_out_t                out_reg;
    sit_out_t                out_next;
    logic                    m_valid_reg;
    logic                    m_valid_next;

    sit_ctl_t ctl;
    sit_rec_t cell_rec   [DEPTH];
    logic     cell_valid [DEPTH];
    logic     cell_found [DEPTH];

    logic     is_write;
    logic     is_full;
    logic     rd_ok;
    sit_rec_t rd_rec;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg         <= s_data.cmd;
            index_reg       <= s_data.index;
            rec_in_reg.head <= s_data.text_head;
            rec_in_reg.tail <= s_data.text_tail;
            key_reg         <= key_of(s_data.text_head);
        end
        out_reg <= out_next;
    end

    assign is_write = (cmd_reg == CMD_APPEND) || (cmd_reg == CMD_INSERT);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign rd_ok    = (32'(index_reg) < 32'(count_reg));

    // Read selection over the row of cells.
    always_comb begin
        rd_rec = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (int'(index_reg) == i) begin
                rd_rec = cell_rec[i];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        ctl.cmp_en   = 1'b0;
        ctl.load_en  = 1'b0;
        ctl.ins      = (cmd_reg == CMD_INSERT);
        ctl.key      = key_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                ctl.cmp_en = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (!m_valid_reg || m_ready) begin
                    out_next = '0;
                    if (is_write) begin
                        if (is_full) begin
                            out_next.error = 1'b1;
                        end else begin
                            ctl.load_en = 1'b1;
                            count_next  = count_reg + 1'b1;
                        end
                    end else if (cmd_reg == CMD_READ) begin
                        if (rd_ok) begin
                            out_next.entry_head = rd_rec.head;
                            out_next.entry_tail = rd_rec.tail;
                        end else begin
                            out_next.error = 1'b1;
                        end
                    end
                    out_next.fill_count = 7'(32'(count_next));
                    m_valid_next        = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The row of cells. Cell 0 sees an always-valid, never-found left neighbor, so
    // it is the insert position of an empty table.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sit_rec_t left_rec;
        logic     left_valid;
        logic     left_found;

        if (g == 0) begin : g_first
            assign left_rec   = '0;
            assign left_valid = 1'b1;
            assign left_found = 1'b0;
        end else begin : g_rest
            assign left_rec   = cell_rec[g-1];
            assign left_valid = cell_valid[g-1];
            assign left_found = cell_found[g-1];
        end

        sit_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctl_i        (ctl),
            .new_rec_i    (rec_in_reg),
            .left_rec_i   (left_rec),
            .left_valid_i (left_valid),
            .left_found_i (left_found),
            .rec_o        (cell_rec[g]),
            .valid_o      (cell_valid[g]),
            .found_o      (cell_found[g])
        );
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
